@@ rtl/dlfp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlfp_pkg
// Shared types, constants and rate tables for the DVD LPCM frame packer.
// ---------------------------------------------------------------------------
package dlfp_pkg;

  // Width of the signed group offset between a chunk start and a frame start
  localparam int OFFSET_BITS = 24;

  // Frame time is offset * 90000 / rate. 48k, 96k and 32k reduce to a small
  // multiplier over a power of two; 44.1k is 2 + 2/49 and uses a reciprocal.
  localparam int NUM_W    = 7;
  localparam int SH_W     = 3;
  localparam int RECIP_SH = OFFSET_BITS + 7;
  localparam int RECIP_W  = OFFSET_BITS + 2;
  localparam int MUL_W    = 2 * OFFSET_BITS + 3;
  localparam int QUO_W    = OFFSET_BITS + 2;
  localparam longint unsigned RECIP_49_FULL =
    ((64'd1 << RECIP_SH) + 64'd48) / 64'd49;
  localparam logic [RECIP_W-1:0] RECIP_49 = RECIP_W'(RECIP_49_FULL);

  localparam int PTS_W  = 33;
  localparam int GI_W   = 8;   // group index inside a frame, up to 160 groups
  localparam int IG_W   = 3;   // word index inside a group, up to 8 channels
  localparam int FN_W   = 5;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_RATE_SELECT   = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;

  // Sample rate codes
  localparam logic [1:0] RATE_48K  = 2'd0;
  localparam logic [1:0] RATE_96K  = 2'd1;
  localparam logic [1:0] RATE_44K1 = 2'd2;
  localparam logic [1:0] RATE_32K  = 2'd3;

  localparam logic [1:0] RATE_RESET = RATE_48K;
  localparam logic [3:0] CHAN_RESET = 4'd2;
  localparam logic [3:0] CHAN_MAX   = 4'd8;

  // Header words
  localparam logic [15:0] HDR_FRAMES_WORD = 16'h0100;
  localparam logic [7:0]  DRC_NEUTRAL     = 8'h80;

  typedef struct packed {
    logic [15:0]      sample;
    logic             chunk_first;
    logic [PTS_W-1:0] chunk_pts;
  } in_item_t;

  typedef struct packed {
    logic [15:0]      frame_word;
    logic             is_header;
    logic             frame_last;
    logic [PTS_W-1:0] frame_pts;
  } out_item_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [15:0]            sample;
    logic                   hdr;
    logic                   last;
    logic [FN_W-1:0]        frame_no;
    logic [1:0]             rate;
    logic [2:0]             chan_m1;
    logic [OFFSET_BITS-1:0] offset;
    logic [PTS_W-1:0]       base_pts;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_MUL,
    ST_DIV,
    ST_DATA
  } back_state_e;

  // Sample groups per frame
  function automatic logic [GI_W-1:0] group_count(input logic [1:0] rate);
    logic [GI_W-1:0] n;
    case (rate)
      RATE_48K:  n = 8'd80;
      RATE_96K:  n = 8'd160;
      RATE_44K1: n = 8'd73;
      RATE_32K:  n = 8'd53;
      default:   n = 8'd80;
    endcase
    return n;
  endfunction

  // 90000 / rate as multiplier over 2^shift; 44.1k takes the reciprocal path
  function automatic logic [NUM_W-1:0] ratio_num(input logic [1:0] rate);
    logic [NUM_W-1:0] n;
    case (rate)
      RATE_48K:  n = 7'd15;
      RATE_96K:  n = 7'd15;
      RATE_32K:  n = 7'd45;
      default:   n = 7'd15;
    endcase
    return n;
  endfunction

  function automatic logic [SH_W-1:0] ratio_shift(input logic [1:0] rate);
    logic [SH_W-1:0] s;
    case (rate)
      RATE_48K:  s = 3'd3;
      RATE_96K:  s = 3'd4;
      RATE_32K:  s = 3'd4;
      default:   s = 3'd3;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/dvd_lpcm_frame_packer_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dvd_lpcm_frame_packer_unit
// Packs interleaved 16-bit PCM sample words into DVD LPCM frames.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_item_i and raise push; a word is taken on a
//   clock edge with push high and full low. Result side: while empty is low
//   the oldest result word sits on out_item_o; pop takes it.
//   Config: cfg_valid_i with cfg_index_i (0 rate select, 1 channel count)
//   and cfg_data_i; cfg_ready_o is always high. Write only while idle; a
//   write restarts framing at a frame boundary with frame number zero.
// Flow:
//   A taken word is written into the queue; the back end, when idle, reads
//   it into its work register and then loads its result word. A frame
//   start first emits three header words, and a frame end first works out
//   the timestamp (a multiply, then a shift or a reciprocal step). The back
//   end takes no new word until the result word of the last one is loaded.
//   A two-entry queue decouples input from output.
// Reset: rate 48 kHz, 2 channels, all framing and chunk state cleared.
// Stall: when pop stays low the result word holds, the back end waits and
//   the queue fills, then full rises.
// ---------------------------------------------------------------------------
module dvd_lpcm_frame_packer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                push,
  output logic                full,
  input  dlfp_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output dlfp_pkg::out_item_t out_item_o
);

  logic            q_wr, q_full, q_rd, q_empty;
  dlfp_pkg::work_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  // Front end: config, position tracking, classification
  dlfp_front u_front (
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_data_o    (q_wdata)
  );

  // Decoupling queue
  dlfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  // Back end: header, timestamp and word output
  dlfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .item_o    (out_item_o)
  );

endmodule

@@ rtl/dlfp_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlfp_front
// Accepts sample words, tracks frame and chunk position, holds the
// configuration registers and classifies each word for the back end.
// ---------------------------------------------------------------------------
module dlfp_front (
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dlfp_pkg::in_item_t  item_i,
  input  logic                q_full_i,
  output logic                q_wr_o,
  output dlfp_pkg::work_t     q_data_o
);

  localparam int OB = dlfp_pkg::OFFSET_BITS;
  localparam logic [OB-1:0] OFF_MAX = {1'b0, {(OB-1){1'b1}}};

  logic [1:0]                  rate_q, rate_d;
  logic [3:0]                  chan_q, chan_d;
  logic [dlfp_pkg::GI_W-1:0]   gi_q, gi_d;
  logic [dlfp_pkg::IG_W-1:0]   ig_q, ig_d;
  logic [dlfp_pkg::FN_W-1:0]   fn_q, fn_d;
  logic [OB-1:0]               foff_q, foff_d;
  logic [dlfp_pkg::PTS_W-1:0]  lpts_q, lpts_d;
  logic [OB-1:0]               sinc_q, sinc_d;

  logic [dlfp_pkg::GI_W-1:0]   fs;
  logic [2:0]                  chan_m1;
  logic                        wrapped;
  logic [dlfp_pkg::GI_W-1:0]   gi_e;
  logic [dlfp_pkg::IG_W-1:0]   ig_e;
  logic                        start, grp_end, last, accept;
  logic [OB-1:0]               sinc_t;

  // Channel count in effect, minus one: 0 acts as 1, above 8 acts as 8
  always_comb begin
    if (chan_q == 4'd0) begin
      chan_m1 = 3'd0;
    end else if (chan_q > dlfp_pkg::CHAN_MAX) begin
      chan_m1 = 3'd7;
    end else begin
      chan_m1 = 3'(chan_q - 4'd1);
    end
  end

  assign fs      = dlfp_pkg::group_count(rate_q);
  assign wrapped = (gi_q >= fs);
  assign gi_e    = wrapped ? '0 : gi_q;
  assign ig_e    = wrapped ? '0 : ig_q;
  assign start   = (gi_e == '0) && (ig_e == '0);
  assign grp_end = (ig_e == chan_m1);
  assign last    = grp_end && (gi_e == fs - 8'd1);
  assign accept  = push_i && !q_full_i;
  assign q_wr_o  = accept;

  // Position, chunk and frame bookkeeping
  always_comb begin
    rate_d = rate_q;
    chan_d = chan_q;
    gi_d   = gi_q;
    ig_d   = ig_q;
    fn_d   = fn_q;
    foff_d = foff_q;
    lpts_d = lpts_q;
    sinc_d = sinc_q;
    sinc_t = sinc_q;

    if (start) begin
      foff_d = sinc_q;
    end
    if (item_i.chunk_first) begin
      lpts_d = item_i.chunk_pts;
      sinc_t = '0;
      foff_d = OB'(0) - {{(OB-dlfp_pkg::GI_W){1'b0}}, gi_e};
    end

    if (accept) begin
      if (grp_end) begin
        sinc_d = (sinc_t < OFF_MAX) ? sinc_t + OB'(1) : OFF_MAX;
      end else begin
        sinc_d = sinc_t;
      end
      if (last) begin
        fn_d = fn_q + 5'd1;
        gi_d = '0;
        ig_d = '0;
      end else if (grp_end) begin
        gi_d = gi_e + 8'd1;
        ig_d = '0;
      end else begin
        gi_d = gi_e;
        ig_d = ig_e + 3'd1;
      end
    end else begin
      foff_d = foff_q;
      lpts_d = lpts_q;
    end

    // Register writes clear frame state
    if (cfg_valid_i &&
        (cfg_index_i == dlfp_pkg::CFG_RATE_SELECT ||
         cfg_index_i == dlfp_pkg::CFG_CHANNEL_COUNT)) begin
      if (cfg_index_i == dlfp_pkg::CFG_RATE_SELECT) begin
        rate_d = cfg_data_i[1:0];
      end else begin
        chan_d = cfg_data_i;
      end
      gi_d   = '0;
      ig_d   = '0;
      fn_d   = '0;
      foff_d = '0;
    end
  end

  // Classified word for the back end
  always_comb begin
    q_data_o.sample   = item_i.sample;
    q_data_o.hdr      = start;
    q_data_o.last     = last;
    q_data_o.frame_no = fn_q;
    q_data_o.rate     = rate_q;
    q_data_o.chan_m1  = chan_m1;
    q_data_o.offset   = foff_d;
    q_data_o.base_pts = lpts_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= dlfp_pkg::RATE_RESET;
      chan_q <= dlfp_pkg::CHAN_RESET;
      gi_q   <= '0;
      ig_q   <= '0;
      fn_q   <= '0;
      foff_q <= '0;
      lpts_q <= '0;
      sinc_q <= '0;
    end else begin
      rate_q <= rate_d;
      chan_q <= chan_d;
      gi_q   <= gi_d;
      ig_q   <= ig_d;
      fn_q   <= fn_d;
      foff_q <= foff_d;
      lpts_q <= lpts_d;
      sinc_q <= sinc_d;
    end
  end

endmodule

@@ rtl/dlfp_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlfp_queue
// Short register queue of classified words between front and back end.
// ---------------------------------------------------------------------------
module dlfp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  dlfp_pkg::work_t  wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output dlfp_pkg::work_t  rd_data_o,
  output logic             empty_o
);

  dlfp_pkg::work_t             mem_q [dlfp_pkg::Q_DEPTH];
  logic [dlfp_pkg::Q_AW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [dlfp_pkg::Q_CW-1:0]   cnt_q, cnt_d;
  logic                        do_wr, do_rd;

  assign full_o    = (cnt_q == dlfp_pkg::Q_CW'(dlfp_pkg::Q_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  // Pointer and fill count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d = (wp_q == dlfp_pkg::Q_AW'(dlfp_pkg::Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_rd) begin
      rp_d = (rp_q == dlfp_pkg::Q_AW'(dlfp_pkg::Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/dlfp_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlfp_back
// Emits header and sample words, works out the frame timestamp with a
// multiply and a shift or reciprocal step, and holds the result word until
// it is popped.
// ---------------------------------------------------------------------------
module dlfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  dlfp_pkg::work_t     q_data_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output dlfp_pkg::out_item_t item_o
);

  localparam int OB = dlfp_pkg::OFFSET_BITS;
  localparam int MW = dlfp_pkg::MUL_W;
  localparam int QW = dlfp_pkg::QUO_W;

  dlfp_pkg::back_state_e       state_q, state_d;
  dlfp_pkg::work_t             w_q, w_d;
  logic [MW-1:0]               prod_q, prod_d;
  logic [QW-1:0]               quo_q, quo_d;
  logic                        ovld_q, ovld_d;
  dlfp_pkg::out_item_t         out_q, out_d;

  logic                        slot_free, neg, is_44k1;
  logic [OB-1:0]               mag;
  logic [OB:0]                 mag2;
  logic [MW-1:0]               prod;
  logic [QW-1:0]               quo;
  logic [QW+dlfp_pkg::PTS_W-1:0] q_ext;
  logic [dlfp_pkg::PTS_W-1:0]  pts;

  // Magnitude of the signed offset
  assign neg     = w_q.offset[OB-1];
  assign mag     = neg ? (OB'(0) - w_q.offset) : w_q.offset;
  assign mag2    = {mag, 1'b0};
  assign is_44k1 = (w_q.rate == dlfp_pkg::RATE_44K1);

  // Product: 2*mag times the reciprocal of 49, or mag times the rate multiplier
  assign prod = is_44k1 ? (MW'(mag2) * MW'(dlfp_pkg::RECIP_49))
                        : (MW'(mag) * MW'(dlfp_pkg::ratio_num(w_q.rate)));

  // Quotient: 2*mag + 2*mag/49 at 44.1k, else a plain shift
  assign quo = is_44k1 ? (QW'(mag2) + QW'(prod_q >> dlfp_pkg::RECIP_SH))
                       : QW'(prod_q >> dlfp_pkg::ratio_shift(w_q.rate));

  // Frame timestamp, wrapping mod 2^33
  assign q_ext = {{dlfp_pkg::PTS_W{1'b0}}, quo_q};
  assign pts   = neg ? (w_q.base_pts - q_ext[dlfp_pkg::PTS_W-1:0])
                     : (w_q.base_pts + q_ext[dlfp_pkg::PTS_W-1:0]);

  assign slot_free = !ovld_q || pop_i;
  assign empty_o   = !ovld_q;
  assign item_o    = out_q;

  // Sequencer: headers, timestamp, sample word
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    ovld_d  = ovld_q;
    out_d   = out_q;
    q_rd_o  = 1'b0;

    if (pop_i && ovld_q) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      dlfp_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          w_d    = q_data_i;
          q_rd_o = 1'b1;
          if (q_data_i.hdr) begin
            state_d = dlfp_pkg::ST_HDR0;
          end else if (q_data_i.last) begin
            state_d = dlfp_pkg::ST_MUL;
          end else begin
            state_d = dlfp_pkg::ST_DATA;
          end
        end
      end
      dlfp_pkg::ST_HDR0: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          out_d   = '{dlfp_pkg::HDR_FRAMES_WORD, 1'b1, 1'b0, '0};
          state_d = dlfp_pkg::ST_HDR1;
        end
      end
      dlfp_pkg::ST_HDR1: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          out_d   = '{{11'd0, w_q.frame_no}, 1'b1, 1'b0, '0};
          state_d = dlfp_pkg::ST_HDR2;
        end
      end
      dlfp_pkg::ST_HDR2: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          out_d   = '{{2'b00, w_q.rate, 1'b0, w_q.chan_m1, dlfp_pkg::DRC_NEUTRAL},
                      1'b1, 1'b0, '0};
          state_d = w_q.last ? dlfp_pkg::ST_MUL : dlfp_pkg::ST_DATA;
        end
      end
      dlfp_pkg::ST_MUL: begin
        prod_d  = prod;
        state_d = dlfp_pkg::ST_DIV;
      end
      dlfp_pkg::ST_DIV: begin
        quo_d   = quo;
        state_d = dlfp_pkg::ST_DATA;
      end
      dlfp_pkg::ST_DATA: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          out_d   = '{w_q.sample, 1'b0, w_q.last, w_q.last ? pts : '0};
          state_d = dlfp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dlfp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlfp_pkg::ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    out_q  <= out_d;
  end

endmodule
